// ===== rtl/asrb_pkg.sv =====
// Shared types and constants for the acked send ring buffer.
// No dependencies; every other file in rtl/ uses this package.
`default_nettype none

package asrb_pkg;

    localparam int DEF_CAPACITY = 4096;
    localparam int OFS_W        = 62;
    localparam int CNT_W        = 13;
    localparam int IDX_W        = 12;
    localparam int BYTE_W       = 8;

    // Operation codes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_PEEK = 2'd1;
    localparam logic [1:0] OP_SENT = 2'd2;
    localparam logic [1:0] OP_ACK  = 2'd3;

    // Status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_REJ = 1'b1;

    typedef struct packed {
        logic [1:0]        operation;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  peek_index;
        logic [CNT_W-1:0]  sent_amount;
        logic [OFS_W-1:0]  ack_offset;
    } t_in_word;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] read_byte;
        logic [CNT_W-1:0]  contiguous_count;
        logic [CNT_W-1:0]  unsent_count;
        logic [CNT_W-1:0]  free_space;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY,
        S_REPORT
    } t_state;

    // Sequencing commands from controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic apply;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/asrb_ctrl.sv =====
// Controller state machine for the acked send ring buffer.
// Depends on asrb_pkg; drives the datapath command struct.
`default_nettype none

module asrb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   o_done,
    output asrb_pkg::t_dp_cmd      o_cmd
);

    asrb_pkg::t_state r_state;
    asrb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asrb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            asrb_pkg::S_IDLE: begin
                if (start) begin
                    n_state = asrb_pkg::S_EVAL;
                end
            end
            asrb_pkg::S_EVAL:   n_state = asrb_pkg::S_APPLY;
            asrb_pkg::S_APPLY:  n_state = asrb_pkg::S_REPORT;
            asrb_pkg::S_REPORT: n_state = asrb_pkg::S_IDLE;
            default:            n_state = asrb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        busy        = 1'b1;
        o_done      = 1'b0;
        o_cmd       = '0;
        case (r_state)
            asrb_pkg::S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            asrb_pkg::S_EVAL:   o_cmd.eval  = 1'b1;
            asrb_pkg::S_APPLY:  o_cmd.apply = 1'b1;
            asrb_pkg::S_REPORT: o_done      = 1'b1;
            default:            busy        = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/asrb_dpath.sv =====
// Datapath for the acked send ring buffer: pointers, offsets, byte store.
// Depends on asrb_pkg; sequenced by asrb_ctrl.
`default_nettype none

module asrb_dpath #(
    parameter int CAPACITY = asrb_pkg::DEF_CAPACITY
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire asrb_pkg::t_dp_cmd    i_cmd,
    input  wire asrb_pkg::t_in_word   i_word,
    output asrb_pkg::t_out_word       o_word
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    // Wide enough for counts, port fields and sums of two indexes
    localparam int XW = ((CW > asrb_pkg::CNT_W) ? CW : asrb_pkg::CNT_W) + 1;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
    localparam int OW = asrb_pkg::OFS_W;

    logic [asrb_pkg::BYTE_W-1:0] r_mem [CAPACITY];

    asrb_pkg::t_in_word r_word;
    logic [AW-1:0]      r_head;
    logic [CW-1:0]      r_occ;
    logic [CW-1:0]      r_unack;
    logic [AW-1:0]      r_ubegin;
    logic [OW-1:0]      r_sent;
    logic [OW-1:0]      r_acked;
    logic               r_reject;
    logic [AW-1:0]      r_addr;
    logic [OW:0]        r_diff;
    logic               r_over;
    logic [asrb_pkg::BYTE_W-1:0] r_rdata;

    logic [XW-1:0] unsent_x, room_x, contig_x, free_x;
    logic [XW-1:0] tail_sum, tail_x, peek_sum, peek_x;
    logic [XW-1:0] ubeg_sum, ubeg_x, inc_x, head_sum, head_x;
    logic          ack_adv, ack_big, ack_bad, ack_commit;
    logic          n_reject;
    logic [AW-1:0] n_addr;

    // Derived counts, always taken from the current pointers
    always_comb begin
        unsent_x = XW'(r_occ) - XW'(r_unack);
        room_x   = CAP_X - XW'(r_ubegin);
        contig_x = (unsent_x < room_x) ? unsent_x : room_x;
        free_x   = CAP_X - XW'(r_occ);
    end

    // Evaluation: checks and store address
    always_comb begin
        tail_sum = XW'(r_head) + XW'(r_occ);
        tail_x   = (tail_sum >= CAP_X) ? tail_sum - CAP_X : tail_sum;
        peek_sum = XW'(r_ubegin) + XW'(r_word.peek_index);
        peek_x   = (peek_sum >= CAP_X) ? peek_sum - CAP_X : peek_sum;
        n_reject = asrb_pkg::ST_OK;
        n_addr   = tail_x[AW-1:0];
        case (r_word.operation)
            asrb_pkg::OP_PUSH: n_reject = (XW'(r_occ) >= CAP_X);
            asrb_pkg::OP_PEEK: begin
                n_reject = (XW'(r_word.peek_index) >= contig_x);
                n_addr   = peek_x[AW-1:0];
            end
            asrb_pkg::OP_SENT: n_reject = (XW'(r_word.sent_amount) > unsent_x);
            default:           n_reject = asrb_pkg::ST_OK;
        endcase
    end

    // Apply: ack decision and pointer advances
    always_comb begin
        ack_adv    = !r_diff[OW] && (r_diff[OW-1:0] != '0);
        ack_big    = r_diff[OW-1:0] > OW'(r_unack);
        ack_bad    = r_over || (ack_adv && ack_big);
        ack_commit = ack_adv && !ack_bad;
        inc_x      = XW'(r_diff[CW-1:0]);
        head_sum   = XW'(r_head) + inc_x;
        head_x     = (head_sum >= CAP_X) ? head_sum - CAP_X : head_sum;
        ubeg_sum   = XW'(r_ubegin) + XW'(r_word.sent_amount);
        ubeg_x     = (ubeg_sum >= CAP_X) ? ubeg_sum - CAP_X : ubeg_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_word;
        end
        if (i_cmd.eval) begin
            r_reject <= n_reject;
            r_addr   <= n_addr;
            r_over   <= (r_word.ack_offset > r_sent);
            r_diff   <= {1'b0, r_word.ack_offset} - {1'b0, r_acked};
        end
        if (i_cmd.apply && (r_word.operation == asrb_pkg::OP_ACK)) begin
            r_reject <= ack_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_occ    <= '0;
            r_unack  <= '0;
            r_ubegin <= '0;
            r_sent   <= '0;
            r_acked  <= '0;
        end else if (i_cmd.apply) begin
            case (r_word.operation)
                asrb_pkg::OP_PUSH: begin
                    if (!r_reject) begin
                        r_occ <= r_occ + CW'(1);
                    end
                end
                asrb_pkg::OP_SENT: begin
                    if (!r_reject) begin
                        r_sent   <= r_sent + OW'(r_word.sent_amount);
                        r_unack  <= r_unack + CW'(r_word.sent_amount);
                        r_ubegin <= ubeg_x[AW-1:0];
                    end
                end
                asrb_pkg::OP_ACK: begin
                    if (ack_commit) begin
                        r_acked <= r_word.ack_offset;
                        r_head  <= head_x[AW-1:0];
                        r_occ   <= r_occ - inc_x[CW-1:0];
                        r_unack <= r_unack - inc_x[CW-1:0];
                    end
                end
                default: r_head <= r_head;
            endcase
        end
    end

    // Byte store: write on accepted push, read every apply cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && (r_word.operation == asrb_pkg::OP_PUSH) && !r_reject) begin
            r_mem[r_addr] <= r_word.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_comb begin
        o_word.status           = r_reject;
        o_word.read_byte        = ((r_word.operation == asrb_pkg::OP_PEEK) && !r_reject)
                                  ? r_rdata : '0;
        o_word.contiguous_count = contig_x[asrb_pkg::CNT_W-1:0];
        o_word.unsent_count     = unsent_x[asrb_pkg::CNT_W-1:0];
        o_word.free_space       = free_x[asrb_pkg::CNT_W-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/acked_send_ring_buffer.sv =====
// Top level of the acked send ring buffer: controller plus datapath.
// Depends on asrb_pkg, asrb_ctrl and asrb_dpath.
//
// Usage:
//   Drive a command word on i_cmd and raise start. The word is taken at the
//   rising edge where start is high and busy is low; busy then stays high
//   until the result has been shown.
//   Operations: push a byte at the tail, peek an unsent byte inside the run
//   before the wrap, mark bytes as sent, or take a cumulative ack offset.
//   Each command returns exactly one result word on o_result, marked by
//   o_done for one cycle: status, peeked byte, and the counts after the op.
//   The receiver cannot stall; it must take the word in the o_done cycle.
// Sequencing:
//   After the accepting edge the controller steps through evaluate, apply
//   and report, raising o_done in report, then returns to idle, where the
//   next word can be taken; no new command is taken before the last one
//   has reported. The registered read port of the byte store sets the
//   apply-then-report split.
// Reset:
//   Synchronous, active low. Pointers, counts and offsets clear to zero; the
//   byte store is not cleared, only written entries are ever shown.
`default_nettype none

module acked_send_ring_buffer #(
    parameter int CAPACITY = asrb_pkg::DEF_CAPACITY
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire asrb_pkg::t_in_word   i_cmd,
    output logic                      busy,
    output logic                      o_done,
    output asrb_pkg::t_out_word       o_result
);

    asrb_pkg::t_dp_cmd dp_cmd;

    // Sequence each command through evaluate, apply and report
    asrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd)
    );

    // Hold the pointers, offsets and byte store
    asrb_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_word  (i_cmd),
        .o_word  (o_result)
    );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for acked_send_ring_buffer: a queue-fed driver, a result monitor and a
// cycle-free predictor of the buffer's pointers and counts.
// Depends on asrb_pkg and the RTL under rtl/.

module tb_top;

    localparam int CAP          = asrb_pkg::DEF_CAPACITY;
    localparam int OW           = asrb_pkg::OFS_W;
    localparam int CW           = asrb_pkg::CNT_W;
    localparam int IW           = asrb_pkg::IDX_W;
    localparam int BW           = asrb_pkg::BYTE_W;
    localparam int RAND_ITEMS   = 1850;
    localparam int DRAIN_CYCLES = 16;
    localparam int TIMEOUT      = 1000000;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    asrb_pkg::t_in_word  i_cmd   = '0;
    logic                busy;
    logic                o_done;
    asrb_pkg::t_out_word o_result;

    acked_send_ring_buffer #(
        .CAPACITY (CAP)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Shadow copy of the buffer state, advanced once per accepted word.
    logic [BW-1:0] ring_mem [CAP];
    logic [IW-1:0] ring_head = '0;
    int            ring_fill = 0;
    logic [OW-1:0] tx_ofs    = '0;
    logic [OW-1:0] ack_ofs   = '0;

    asrb_pkg::t_in_word  cmd_q[$];
    asrb_pkg::t_out_word report_q[$];
    bit                  holding       = 1'b0;
    int                  gap_left      = 0;
    bit                  quiet_stretch = 1'b0;
    int                  err_cnt       = 0;

    function automatic logic [OW-1:0] in_flight();
        return tx_ofs - ack_ofs;
    endfunction

    function automatic int unsent_bytes();
        logic [OW-1:0] s;
        s = in_flight();
        if (s > OW'(ring_fill)) return 0;
        return ring_fill - int'(s);
    endfunction

    function automatic int unsent_start();
        logic [OW-1:0] s;
        s = in_flight() % OW'(CAP);
        return (int'(ring_head) + int'(s)) % CAP;
    endfunction

    function automatic int contig_run();
        int t;
        int room;
        t    = unsent_bytes();
        room = CAP - unsent_start();
        return (t < room) ? t : room;
    endfunction

    // Apply one command to the shadow state and return the report it yields.
    function automatic asrb_pkg::t_out_word apply_cmd(input asrb_pkg::t_in_word w);
        asrb_pkg::t_out_word r;
        logic [OW-1:0]       inc;
        int                  slot;
        r        = '0;
        r.status = asrb_pkg::ST_OK;
        case (w.operation)
            asrb_pkg::OP_PUSH: begin
                if (ring_fill >= CAP) begin
                    r.status = asrb_pkg::ST_REJ;
                end else begin
                    slot           = (int'(ring_head) + ring_fill) % CAP;
                    ring_mem[slot] = w.data_byte;
                    ring_fill++;
                end
            end
            asrb_pkg::OP_PEEK: begin
                if (int'(w.peek_index) >= contig_run()) begin
                    r.status = asrb_pkg::ST_REJ;
                end else begin
                    r.read_byte = ring_mem[(unsent_start() + int'(w.peek_index)) % CAP];
                end
            end
            asrb_pkg::OP_SENT: begin
                if (int'(w.sent_amount) > unsent_bytes()) begin
                    r.status = asrb_pkg::ST_REJ;
                end else begin
                    tx_ofs = tx_ofs + OW'(w.sent_amount);
                end
            end
            asrb_pkg::OP_ACK: begin
                if (w.ack_offset > tx_ofs) begin
                    r.status = asrb_pkg::ST_REJ;
                end else if (w.ack_offset > ack_ofs) begin
                    inc = w.ack_offset - ack_ofs;
                    if (inc > OW'(ring_fill) || inc > in_flight()) begin
                        r.status = asrb_pkg::ST_REJ;
                    end else begin
                        ack_ofs   = w.ack_offset;
                        ring_head = IW'((int'(ring_head) + int'(inc)) % CAP);
                        ring_fill = ring_fill - int'(inc);
                    end
                end
                // stale acks fall through: accepted, nothing moves
            end
            default: ;
        endcase
        r.contiguous_count = CW'(contig_run());
        r.unsent_count     = CW'(unsent_bytes());
        r.free_space       = CW'(CAP - ring_fill);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet_stretch) return 0;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(4, 1);
        if (r < 97) return $urandom_range(10, 5);
        return $urandom_range(40, 11);
    endfunction

    // Driver: hold start until the word is taken, then idle for a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                report_q.push_back(apply_cmd(i_cmd));
                holding  = 1'b0;
                gap_left = pick_gap();
            end
            if (!holding && gap_left == 0 && cmd_q.size() != 0) begin
                i_cmd   <= cmd_q.pop_front();
                start   <= 1'b1;
                holding  = 1'b1;
            end else if (!holding) begin
                start <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    task automatic check_field(input string tag, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, tag, want_v, got_v);
        end
    endtask

    asrb_pkg::t_out_word want;

    // Monitor: every strobed report must match the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (report_q.size() == 0) begin
                err_cnt++;
                $display("%0t: report with no command pending, expected none, actual %0h",
                         $time, o_result);
            end else begin
                want = report_q.pop_front();
                check_field("status", 64'(want.status), 64'(o_result.status));
                check_field("read_byte", 64'(want.read_byte), 64'(o_result.read_byte));
                check_field("contiguous_count", 64'(want.contiguous_count),
                            64'(o_result.contiguous_count));
                check_field("unsent_count", 64'(want.unsent_count),
                            64'(o_result.unsent_count));
                check_field("free_space", 64'(want.free_space), 64'(o_result.free_space));
            end
        end
    end

    function automatic asrb_pkg::t_in_word cmd_word(input logic [1:0] op, input int data,
                                                    input int idx, input int amt,
                                                    input logic [OW-1:0] ofs);
        asrb_pkg::t_in_word w;
        w.operation   = op;
        w.data_byte   = BW'(data);
        w.peek_index  = IW'(idx);
        w.sent_amount = CW'(amt);
        w.ack_offset  = ofs;
        return w;
    endfunction

    function automatic asrb_pkg::t_in_word noise_word();
        asrb_pkg::t_in_word w;
        w.operation   = 2'($urandom_range(3, 0));
        w.data_byte   = BW'($urandom);
        w.peek_index  = IW'($urandom);
        w.sent_amount = CW'($urandom);
        w.ack_offset  = OW'({$urandom, $urandom});
        return w;
    endfunction

    // Build a command of the given kind, mostly legal for the current state,
    // sometimes right at or past the legal edge. Unused fields carry noise.
    function automatic asrb_pkg::t_in_word shape_word(input logic [1:0] op);
        asrb_pkg::t_in_word w;
        int                 c;
        int                 u;
        int                 pick;
        logic [OW-1:0]      f;
        w           = noise_word();
        w.operation = op;
        c           = contig_run();
        u           = unsent_bytes();
        f           = in_flight();
        pick        = $urandom_range(99, 0);
        case (op)
            asrb_pkg::OP_PEEK: begin
                if (pick < 75 && c > 0) w.peek_index = IW'($urandom_range(c - 1, 0));
                else if (pick < 90) w.peek_index = (c >= CAP) ? IW'(CAP - 1) : IW'(c);
            end
            asrb_pkg::OP_SENT: begin
                if (pick < 40) w.sent_amount = CW'($urandom_range((u < 16) ? u : 16, 0));
                else if (pick < 65) w.sent_amount = CW'($urandom_range(u, 0));
                else if (pick < 75) w.sent_amount = CW'(u);
                else if (pick < 85) w.sent_amount = CW'(u + 1);
                else if (pick < 90) w.sent_amount = '0;
            end
            asrb_pkg::OP_ACK: begin
                if (pick < 55 && f > 0)
                    w.ack_offset = ack_ofs + OW'($urandom_range(int'(f), 1));
                else if (pick < 65)
                    w.ack_offset = ack_ofs
                        - OW'($urandom_range((ack_ofs < 50) ? int'(ack_ofs) : 50, 0));
                else if (pick < 75)
                    w.ack_offset = tx_ofs;
                else if (pick < 85)
                    w.ack_offset = tx_ofs + OW'(1 + $urandom_range(5, 0));
            end
            default: ;
        endcase
        return w;
    endfunction

    function automatic logic [1:0] pick_op(input int mode);
        int r;
        r = $urandom_range(99, 0);
        case (mode)
            0: begin
                if (r < 55) return asrb_pkg::OP_PUSH;
                if (r < 75) return asrb_pkg::OP_PEEK;
                if (r < 88) return asrb_pkg::OP_SENT;
                return asrb_pkg::OP_ACK;
            end
            1: begin
                if (r < 15) return asrb_pkg::OP_PUSH;
                if (r < 35) return asrb_pkg::OP_PEEK;
                if (r < 65) return asrb_pkg::OP_SENT;
                return asrb_pkg::OP_ACK;
            end
            default: begin
                if (r < 30) return asrb_pkg::OP_PUSH;
                if (r < 55) return asrb_pkg::OP_PEEK;
                if (r < 77) return asrb_pkg::OP_SENT;
                return asrb_pkg::OP_ACK;
            end
        endcase
    endfunction

    // Queue one command and wait until the driver has handed it over, so the
    // shadow state is current when the next one is built.
    task automatic post(input asrb_pkg::t_in_word w);
        cmd_q.push_back(w);
        while (cmd_q.size() != 0 || holding) @(negedge i_clk);
    endtask

    initial begin : stim
        int mode;
        // empty buffer: nothing to peek, zero-length send, stale and early acks; then pushes, sends, acks
        post(cmd_word(asrb_pkg::OP_PEEK, 0, 0, 0, 0));
        post(cmd_word(asrb_pkg::OP_SENT, 0, 0, 0, 0));
        post(cmd_word(asrb_pkg::OP_SENT, 0, 0, 1, 0));
        post(cmd_word(asrb_pkg::OP_ACK, 0, 0, 0, 0));
        post(cmd_word(asrb_pkg::OP_ACK, 0, 0, 0, 1));
        post(cmd_word(asrb_pkg::OP_ACK, 0, 0, 0, {OW{1'b1}}));
        post(cmd_word(asrb_pkg::OP_PUSH, 8'h00, 0, 0, 0));
        post(cmd_word(asrb_pkg::OP_PUSH, 8'hFF, 0, 0, 0));
        post(cmd_word(asrb_pkg::OP_PUSH, 8'hA5, 0, 0, 0));
        post(cmd_word(asrb_pkg::OP_PEEK, 0, 0, 0, 0));
        post(cmd_word(asrb_pkg::OP_PEEK, 0, 2, 0, 0));
        post(cmd_word(asrb_pkg::OP_PEEK, 0, 3, 0, 0));
        post(cmd_word(asrb_pkg::OP_PEEK, 0, 4095, 0, 0));
        post(cmd_word(asrb_pkg::OP_SENT, 0, 0, 4096, 0));
        post(cmd_word(asrb_pkg::OP_SENT, 0, 0, 8191, 0));
        post(cmd_word(asrb_pkg::OP_SENT, 0, 0, 2, 0));
        post(cmd_word(asrb_pkg::OP_PEEK, 0, 0, 0, 0));
        post(cmd_word(asrb_pkg::OP_ACK, 0, 0, 0, 3));
        post(cmd_word(asrb_pkg::OP_ACK, 0, 0, 0, 1));
        post(cmd_word(asrb_pkg::OP_ACK, 0, 0, 0, 1));
        post(cmd_word(asrb_pkg::OP_ACK, 0, 0, 0, 0));
        post(cmd_word(asrb_pkg::OP_ACK, 0, 0, 0, 2));
        post(cmd_word(asrb_pkg::OP_SENT, 0, 0, 1, 0));
        post(cmd_word(asrb_pkg::OP_ACK, 0, 0, 0, 3));
        post(cmd_word(asrb_pkg::OP_PEEK, 0, 0, 0, 0));

        // three pushes, then peeks at and past the end of the run, then sends and acks around the legal edge
        repeat (3) post(shape_word(asrb_pkg::OP_PUSH));
        post(cmd_word(asrb_pkg::OP_PEEK, 0, contig_run() - 1, 0, 0));
        post(cmd_word(asrb_pkg::OP_PEEK, 0, 4095, 0, 0));
        repeat (4) post(cmd_word(asrb_pkg::OP_PEEK, 0,
                                 $urandom_range(contig_run() - 1, 2048), 0, 0));
        post(cmd_word(asrb_pkg::OP_SENT, 0, 0, CAP, 0));
        post(cmd_word(asrb_pkg::OP_PEEK, 0, 0, 0, 0));
        post(cmd_word(asrb_pkg::OP_SENT, 0, 0, 1, 0));
        post(cmd_word(asrb_pkg::OP_ACK, 0, 0, 0, tx_ofs + OW'(1)));
        post(cmd_word(asrb_pkg::OP_ACK, 0, 0, 0,
                      ack_ofs + OW'($urandom_range(3000, 1000))));

        // mixed traffic in stretches that lean toward filling, draining or neither
        mode = 2;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 150 == 0) begin
                mode          = $urandom_range(2, 0);
                quiet_stretch = ($urandom_range(3, 0) == 0);
            end
            if ($urandom_range(99, 0) < 8) post(noise_word());
            else post(shape_word(pick_op(mode)));
        end

        while (cmd_q.size() != 0 || holding || report_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #TIMEOUT;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/asrb_pkg.sv
rtl/asrb_ctrl.sv
rtl/asrb_dpath.sv
rtl/acked_send_ring_buffer.sv
sim/tb_top.sv
